/* hw/rtl/assert_macros.svh */
// assertion macros shared by the word wrapper rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// property checked on every clock edge while reset is released
`define GWW_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
// property checked on every clock edge, reset included
`define GWW_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define GWW_ASSERT(lbl, clk, rstn, prop, msg)
`define GWW_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

/* hw/rtl/gww_pkg.sv */
// shared types and constants of the greedy word wrapper
package gww_pkg;

    // character codes
    localparam logic [7:0] CH_SPACE     = 8'h20;
    localparam logic [7:0] CH_NEWLINE   = 8'h0A;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_N         = 8'h6E;

    // line width limits
    localparam logic [5:0] WIDTH_RESET = 6'd58;
    localparam logic [5:0] WIDTH_MAX   = 6'd62;
    localparam logic [5:0] WIDTH_MIN   = 6'd1;

    // sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_START,
        S_FEED,
        S_HOLD_SP,
        S_EMIT_CH,
        S_COL,
        S_WRAP_NL,
        S_HARD_NL,
        S_NEXT,
        S_FLUSH_RD,
        S_FLUSH_EM,
        S_TAIL,
        S_FIN
    } state_t;

    // requests from the sequencer to the output stage
    typedef struct packed {
        logic       emit;
        logic [7:0] data;
        logic       push;
        logic       last;
    } emit_ctl_t;

    // status of the output stage
    typedef struct packed {
        logic ready;
        logic stg_vld;
    } emit_sts_t;

endpackage

/* hw/rtl/gww_ram.sv */
// generic single write port ram with registered read
module gww_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read port, data holds until the next read
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* hw/rtl/gww_emit.sv */
// output stage: one staging byte ahead of the result register
module gww_emit (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  gww_pkg::emit_ctl_t   ctl,
    output gww_pkg::emit_sts_t   sts,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [7:0]           m_out_byte,
    output logic                 m_out_last
);

    logic       stg_vld_reg, stg_vld_next;
    logic [7:0] stg_byte_reg, stg_byte_next;
    logic       m_valid_reg, m_valid_next;
    logic [7:0] m_byte_reg, m_byte_next;
    logic       m_last_reg, m_last_next;
    logic       out_free;
    logic       move;
    logic       move_last;

    // the result register is free or is taken in this cycle
    assign out_free  = !m_valid_reg || m_ready;
    assign sts.ready = !stg_vld_reg || out_free;
    assign sts.stg_vld = stg_vld_reg;

    // staging and result register update
    always_comb begin
        stg_vld_next  = stg_vld_reg;
        stg_byte_next = stg_byte_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_byte_next   = m_byte_reg;
        m_last_next   = m_last_reg;
        move          = 1'b0;
        move_last     = 1'b0;
        if (ctl.emit && sts.ready) begin
            stg_byte_next = ctl.data;
            stg_vld_next  = 1'b1;
            move          = stg_vld_reg;
        end else if (ctl.push && sts.ready) begin
            stg_vld_next = 1'b0;
            move         = stg_vld_reg;
            move_last    = ctl.last;
        end
        if (move) begin
            m_valid_next = 1'b1;
            m_byte_next  = stg_byte_reg;
            m_last_next  = move_last;
        end
    end

    // control flops
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stg_vld_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            stg_vld_reg <= stg_vld_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // payload flops
    always_ff @(posedge aclk) begin
        stg_byte_reg <= stg_byte_next;
        m_byte_reg   <= m_byte_next;
        m_last_reg   <= m_last_next;
    end

    assign m_valid    = m_valid_reg;
    assign m_out_byte = m_byte_reg;
    assign m_out_last = m_last_reg;

endmodule

/* hw/rtl/greedy_word_wrapper_unit.sv */
// greedy word wrapper: one item at a time, s_ready is high only in the idle state
// results leave one emit late through a staging byte
// aresetn (synchronous, active low) clears column, fill count and flags, width goes to 58
// the line buffer ram has no reset; only entries below the fill count are read
`include "assert_macros.svh"

module greedy_word_wrapper_unit #(
    parameter int LINE_BUFFER_DEPTH = 64
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_wr_en,
    input  logic [5:0] cfg_wr_data,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_in_byte,
    input  logic       s_in_last,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_out_byte,
    output logic       m_out_last
);

    localparam int CNT_W = $clog2(LINE_BUFFER_DEPTH + 1);
    localparam int IDX_W = $clog2(LINE_BUFFER_DEPTH);

    gww_pkg::state_t state_reg, state_next;
    gww_pkg::state_t ret_reg, ret_next;

    logic [7:0]       byte_reg, byte_next;
    logic             last_reg, last_next;
    logic [7:0]       feed_ch_reg, feed_ch_next;
    logic             second_reg, second_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [5:0]       column_reg, column_next;
    logic             sah_reg, sah_next;
    logic             bs_reg, bs_next;
    logic [5:0]       lw_reg;

    logic [5:0]       eff_w;
    logic [5:0]       col_inc;
    logic             wrap;
    logic             count_full;
    logic             count_nz;
    logic             idx_more;
    logic             b_is_n;
    logic             hold_bs;

    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr;
    logic [7:0]       mem_wdata;
    logic             mem_re;
    logic [7:0]       mem_rdata;

    gww_pkg::emit_ctl_t ctl;
    gww_pkg::emit_sts_t sts;

    // width register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lw_reg <= gww_pkg::WIDTH_RESET;
        end else if (cfg_wr_en) begin
            lw_reg <= cfg_wr_data;
        end
    end

    // effective width clamped to one through sixty-two
    always_comb begin
        if (lw_reg == 6'd0) begin
            eff_w = gww_pkg::WIDTH_MIN;
        end else if (lw_reg > gww_pkg::WIDTH_MAX) begin
            eff_w = gww_pkg::WIDTH_MAX;
        end else begin
            eff_w = lw_reg;
        end
    end

    // shared conditions
    assign col_inc    = column_reg + 6'd1;
    assign wrap       = col_inc >= eff_w;
    assign count_full = count_reg == CNT_W'(LINE_BUFFER_DEPTH);
    assign count_nz   = count_reg != '0;
    assign idx_more   = idx_reg < count_reg;
    assign b_is_n     = byte_reg == gww_pkg::CH_N;
    assign hold_bs    = (byte_reg == gww_pkg::CH_BACKSLASH) && !last_reg;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            gww_pkg::S_IDLE: begin
                if (s_valid) state_next = gww_pkg::S_START;
            end
            gww_pkg::S_START: begin
                if (bs_reg) begin
                    if (b_is_n) begin
                        state_next = count_nz ? gww_pkg::S_FLUSH_RD : gww_pkg::S_HARD_NL;
                    end else begin
                        state_next = gww_pkg::S_FEED;
                    end
                end else begin
                    state_next = hold_bs ? gww_pkg::S_TAIL : gww_pkg::S_FEED;
                end
            end
            gww_pkg::S_FEED: begin
                if (feed_ch_reg == gww_pkg::CH_SPACE) begin
                    state_next = count_nz ? gww_pkg::S_FLUSH_RD : gww_pkg::S_HOLD_SP;
                end else if (sah_reg) begin
                    state_next = count_full ? gww_pkg::S_FLUSH_RD : gww_pkg::S_COL;
                end else begin
                    state_next = gww_pkg::S_EMIT_CH;
                end
            end
            gww_pkg::S_HOLD_SP: state_next = gww_pkg::S_COL;
            gww_pkg::S_EMIT_CH: begin
                if (sts.ready) state_next = gww_pkg::S_COL;
            end
            gww_pkg::S_COL: state_next = wrap ? gww_pkg::S_WRAP_NL : gww_pkg::S_NEXT;
            gww_pkg::S_WRAP_NL: begin
                if (sts.ready) begin
                    if (sah_reg && (count_reg > CNT_W'(1))) begin
                        state_next = gww_pkg::S_FLUSH_RD;
                    end else begin
                        state_next = gww_pkg::S_NEXT;
                    end
                end
            end
            gww_pkg::S_HARD_NL: begin
                if (sts.ready) state_next = gww_pkg::S_TAIL;
            end
            gww_pkg::S_NEXT: begin
                if (second_reg) begin
                    state_next = hold_bs ? gww_pkg::S_TAIL : gww_pkg::S_FEED;
                end else begin
                    state_next = gww_pkg::S_TAIL;
                end
            end
            gww_pkg::S_FLUSH_RD: state_next = gww_pkg::S_FLUSH_EM;
            gww_pkg::S_FLUSH_EM: begin
                if (sts.ready && !idx_more) state_next = ret_reg;
            end
            gww_pkg::S_TAIL: begin
                state_next = (last_reg && count_nz) ? gww_pkg::S_FLUSH_RD : gww_pkg::S_FIN;
            end
            gww_pkg::S_FIN: begin
                if (sts.ready) state_next = gww_pkg::S_IDLE;
            end
            default: state_next = gww_pkg::S_IDLE;
        endcase
    end

    // datapath, memory and output requests
    always_comb begin
        byte_next    = byte_reg;
        last_next    = last_reg;
        feed_ch_next = feed_ch_reg;
        second_next  = second_reg;
        idx_next     = idx_reg;
        count_next   = count_reg;
        column_next  = column_reg;
        sah_next     = sah_reg;
        bs_next      = bs_reg;
        ret_next     = ret_reg;
        s_ready      = 1'b0;
        mem_we       = 1'b0;
        mem_waddr    = count_reg[IDX_W-1:0];
        mem_wdata    = feed_ch_reg;
        mem_re       = 1'b0;
        ctl          = '0;
        case (state_reg)
            gww_pkg::S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    byte_next = s_in_byte;
                    last_next = s_in_last;
                end
            end
            gww_pkg::S_START: begin
                if (bs_reg) begin
                    bs_next = 1'b0;
                    if (b_is_n) begin
                        idx_next = '0;
                        ret_next = gww_pkg::S_HARD_NL;
                    end else begin
                        feed_ch_next = gww_pkg::CH_BACKSLASH;
                        second_next  = 1'b1;
                    end
                end else if (hold_bs) begin
                    bs_next = 1'b1;
                end else begin
                    feed_ch_next = byte_reg;
                    second_next  = 1'b0;
                end
            end
            gww_pkg::S_FEED: begin
                if (feed_ch_reg == gww_pkg::CH_SPACE) begin
                    idx_next = '0;
                    ret_next = gww_pkg::S_HOLD_SP;
                end else if (sah_reg) begin
                    if (count_full) begin
                        idx_next = '0;
                        ret_next = gww_pkg::S_EMIT_CH;
                    end else begin
                        mem_we     = 1'b1;
                        count_next = count_reg + CNT_W'(1);
                    end
                end
            end
            gww_pkg::S_HOLD_SP: begin
                mem_we     = 1'b1;
                mem_waddr  = '0;
                mem_wdata  = gww_pkg::CH_SPACE;
                count_next = CNT_W'(1);
                sah_next   = 1'b1;
            end
            gww_pkg::S_EMIT_CH: begin
                ctl.emit = 1'b1;
                ctl.data = feed_ch_reg;
            end
            gww_pkg::S_COL: begin
                column_next = col_inc;
            end
            // wrap: the newline is emitted, and a held space, if there is one, turns into it
            gww_pkg::S_WRAP_NL: begin
                ctl.emit = 1'b1;
                ctl.data = gww_pkg::CH_NEWLINE;
                if (sts.ready) begin
                    if (sah_reg) begin
                        column_next = 6'(count_reg - CNT_W'(1));
                        if (count_reg > CNT_W'(1)) begin
                            idx_next = CNT_W'(1);
                            ret_next = gww_pkg::S_NEXT;
                        end else begin
                            count_next = '0;
                            sah_next   = 1'b0;
                        end
                    end else begin
                        column_next = '0;
                    end
                end
            end
            gww_pkg::S_HARD_NL: begin
                ctl.emit = 1'b1;
                ctl.data = gww_pkg::CH_NEWLINE;
                if (sts.ready) begin
                    column_next = '0;
                    sah_next    = 1'b0;
                    count_next  = '0;
                end
            end
            gww_pkg::S_NEXT: begin
                if (second_reg) begin
                    second_next = 1'b0;
                    if (hold_bs) begin
                        bs_next = 1'b1;
                    end else begin
                        feed_ch_next = byte_reg;
                    end
                end
            end
            gww_pkg::S_FLUSH_RD: begin
                mem_re   = 1'b1;
                idx_next = idx_reg + CNT_W'(1);
            end
            // one held byte per cycle while the output stage is ready, next read issued with each accepted emit
            gww_pkg::S_FLUSH_EM: begin
                ctl.emit = 1'b1;
                ctl.data = mem_rdata;
                if (sts.ready) begin
                    if (idx_more) begin
                        mem_re   = 1'b1;
                        idx_next = idx_reg + CNT_W'(1);
                    end else begin
                        count_next = '0;
                        sah_next   = 1'b0;
                    end
                end
            end
            gww_pkg::S_TAIL: begin
                idx_next = '0;
                ret_next = gww_pkg::S_FIN;
            end
            // release the staged byte, tagged last on the final item
            gww_pkg::S_FIN: begin
                ctl.push = 1'b1;
                ctl.last = last_reg;
                if (sts.ready && last_reg) begin
                    count_next  = '0;
                    column_next = '0;
                    sah_next    = 1'b0;
                    bs_next     = 1'b0;
                end
            end
            default: begin
                count_next = count_reg;
            end
        endcase
    end

    // control flops
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= gww_pkg::S_IDLE;
            ret_reg    <= gww_pkg::S_IDLE;
            count_reg  <= '0;
            column_reg <= '0;
            sah_reg    <= 1'b0;
            bs_reg     <= 1'b0;
            second_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            ret_reg    <= ret_next;
            count_reg  <= count_next;
            column_reg <= column_next;
            sah_reg    <= sah_next;
            bs_reg     <= bs_next;
            second_reg <= second_next;
        end
    end

    // payload flops
    always_ff @(posedge aclk) begin
        byte_reg    <= byte_next;
        last_reg    <= last_next;
        feed_ch_reg <= feed_ch_next;
        idx_reg     <= idx_next;
    end

    // line buffer
    gww_ram #(
        .WIDTH (8),
        .DEPTH (LINE_BUFFER_DEPTH)
    ) u_line_buf (
        .aclk    (aclk),
        .wr_en   (mem_we),
        .wr_addr (mem_waddr),
        .wr_data (mem_wdata),
        .rd_en   (mem_re),
        .rd_addr (idx_reg[IDX_W-1:0]),
        .rd_data (mem_rdata)
    );

    // output stage
    gww_emit u_emit (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctl        (ctl),
        .sts        (sts),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_out_byte (m_out_byte),
        .m_out_last (m_out_last)
    );

    // checks
    `GWW_ASSERT(a_cnt_bound, aclk, aresetn, count_reg <= CNT_W'(LINE_BUFFER_DEPTH), "fill count above depth")
    `GWW_ASSERT(a_idle_empty, aclk, aresetn, (state_reg == gww_pkg::S_IDLE) |-> !sts.stg_vld, "staged byte left at idle")
    `GWW_ASSERT(a_flush_idx, aclk, aresetn, (state_reg == gww_pkg::S_FLUSH_EM) |-> (idx_reg != '0 && idx_reg <= count_reg), "flush index out of range")
    `GWW_ASSERT(a_last_clear, aclk, aresetn, (state_reg == gww_pkg::S_FIN && last_reg && sts.ready) |=> (count_reg == '0 && column_reg == '0 && !sah_reg && !bs_reg), "state not cleared after final item")

endmodule
